/* rtl/bchd_pkg.sv */
// ----------------------------------------------------------------------------
// bchd_pkg: shared types and constants for the button click/hold detector
// Register indexes, event codes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package bchd_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int EV_W           = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 2'd3;

	// reset values
	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] DOUBLE_RST   = 16'd300;
	localparam logic [CFG_W-1:0] HOLD_RST     = 16'd2000;

	// event codes
	localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
	localparam logic [EV_W-1:0] EV_CLICK  = 2'd1;
	localparam logic [EV_W-1:0] EV_DOUBLE = 2'd2;
	localparam logic [EV_W-1:0] EV_HOLD   = 2'd3;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ticks;
		logic [CFG_W-1:0] double_click_ticks;
		logic [CFG_W-1:0] hold_ticks;
		logic             active_high;
	} cfg_t;

endpackage

/* rtl/bchd_debounce.sv */
// ----------------------------------------------------------------------------
// bchd_debounce: raw pressed bit debounce
// Counts ticks of unchanged raw bit; accepts it once count exceeds threshold.
// ----------------------------------------------------------------------------
module bchd_debounce #(
	parameter int TIMER_BITS = bchd_pkg::TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  pin,
	input  bchd_pkg::cfg_t        cfg,
	output logic                  level_next
);

	localparam int CMP_W = TIMER_BITS + bchd_pkg::CFG_W;

	logic                  raw;
	logic [TIMER_BITS-1:0] stable_count_q;
	logic [TIMER_BITS-1:0] count_next;
	logic                  prev_raw_q;
	logic                  level_q;

	assign raw = cfg.active_high ? pin : ~pin;

	always_comb begin
		if (raw != prev_raw_q) begin
			count_next = '0;
		end else if (stable_count_q == {TIMER_BITS{1'b1}}) begin
			count_next = stable_count_q;
		end else begin
			count_next = stable_count_q + 1'b1;
		end
		if (CMP_W'(count_next) > CMP_W'(cfg.debounce_ticks)) begin
			level_next = raw;
		end else begin
			level_next = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_count_q <= '0;
			prev_raw_q     <= 1'b0;
			level_q        <= 1'b0;
		end else if (step) begin
			stable_count_q <= count_next;
			prev_raw_q     <= raw;
			level_q        <= level_next;
		end
	end

endmodule

/* rtl/bchd_gesture.sv */
// ----------------------------------------------------------------------------
// bchd_gesture: click / double click / hold state machine
// Tracks press and gap timers against the debounced level, one tick per step.
// ----------------------------------------------------------------------------
module bchd_gesture #(
	parameter int TIMER_BITS = bchd_pkg::TIMER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           level,
	input  bchd_pkg::cfg_t                 cfg,
	output logic [bchd_pkg::EV_W-1:0]      ev
);

	localparam int CMP_W = TIMER_BITS + bchd_pkg::CFG_W;

	typedef enum logic [3:0] {
		M_IDLE    = 4'b0001,
		M_PRESSED = 4'b0010,
		M_WAIT    = 4'b0100,
		M_HOLD    = 4'b1000
	} mode_t;

	mode_t                 mode_q, mode_next;
	logic [TIMER_BITS-1:0] press_q, press_next, press_inc;
	logic [TIMER_BITS-1:0] gap_q, gap_next, gap_inc;
	logic                  hold_hit;
	logic                  gap_hit;

	assign press_inc = (press_q == {TIMER_BITS{1'b1}}) ? press_q : press_q + 1'b1;
	assign gap_inc   = (gap_q == {TIMER_BITS{1'b1}}) ? gap_q : gap_q + 1'b1;
	assign hold_hit  = CMP_W'(press_inc) >= CMP_W'(cfg.hold_ticks);
	assign gap_hit   = CMP_W'(gap_inc) >= CMP_W'(cfg.double_click_ticks);

	always_comb begin
		mode_next  = mode_q;
		press_next = press_q;
		gap_next   = gap_q;
		ev         = bchd_pkg::EV_NONE;
		case (mode_q)
			M_IDLE: begin
				if (level) begin
					mode_next  = M_PRESSED;
					press_next = '0;
				end
			end
			M_PRESSED: begin
				press_next = press_inc;
				if (!level) begin
					// release on or past the hold tick: no event
					if (hold_hit) begin
						mode_next = M_IDLE;
					end else begin
						mode_next = M_WAIT;
						gap_next  = '0;
					end
				end else if (hold_hit) begin
					mode_next = M_HOLD;
					ev        = bchd_pkg::EV_HOLD;
				end
			end
			M_WAIT: begin
				gap_next = gap_inc;
				if (level) begin
					mode_next  = M_PRESSED;
					press_next = '0;
					ev         = bchd_pkg::EV_DOUBLE;
				end else if (gap_hit) begin
					mode_next = M_IDLE;
					ev        = bchd_pkg::EV_CLICK;
				end
			end
			M_HOLD: begin
				if (!level) begin
					mode_next = M_IDLE;
				end
			end
			default: begin
				mode_next = M_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			press_q <= '0;
			gap_q   <= '0;
		end else if (step) begin
			mode_q  <= mode_next;
			press_q <= press_next;
			gap_q   <= gap_next;
		end
	end

endmodule

/* rtl/button_click_hold_detector.sv */
// ----------------------------------------------------------------------------
// button_click_hold_detector: debounced click, double click and hold events
// One input transfer per 1 ms tick carrying the raw pin level; one result
// transfer per tick carrying the event code and the debounced pressed bit.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_stall/pin_level: one transfer per tick.
//  - Output channel out_valid/out_stall/event_code/pressed_now: exactly one
//    transfer per input transfer, in order (0 none, 1 click, 2 double, 3 hold).
//  - Config port cfg_we/cfg_index/cfg_data: 0 debounce, 1 double-click gap,
//    2 hold length, 3 polarity (bit 0). Write only while the block is idle.
//  - An item taken into the input register is worked through the debounce
//    and gesture logic and lands in the result register that drives
//    out_valid. Throughput: one item per cycle while the receiver does not
//    stall; the state commits as each item moves to the result register.
//  - When the receiver stalls, the result register holds; the input register
//    still takes one more item, after which in_stall is raised until the
//    result is taken.
//  - Reset clears all timers, the debounced level (not pressed), the gesture
//    state (idle) and restores the register reset values.
// ----------------------------------------------------------------------------
module button_click_hold_detector #(
	parameter int TIMER_BITS = bchd_pkg::TIMER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              pin_level,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bchd_pkg::EV_W-1:0]         event_code,
	output logic                              pressed_now,
	// configuration
	input  logic                              cfg_we,
	input  logic [bchd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bchd_pkg::CFG_W-1:0]        cfg_data
);

	bchd_pkg::cfg_t              cfg_q;

	logic                        valid_s1;
	logic                        pin_s1;
	logic                        advance;
	logic                        in_take;

	logic                        level_next;
	logic [bchd_pkg::EV_W-1:0]   ev;

	logic                        out_valid_q;
	logic [bchd_pkg::EV_W-1:0]   event_q;
	logic                        pressed_q;

	// stage 1 moves to the result register when that register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks     <= bchd_pkg::DEBOUNCE_RST;
			cfg_q.double_click_ticks <= bchd_pkg::DOUBLE_RST;
			cfg_q.hold_ticks         <= bchd_pkg::HOLD_RST;
			cfg_q.active_high        <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bchd_pkg::REG_DEBOUNCE: cfg_q.debounce_ticks     <= cfg_data;
				bchd_pkg::REG_DOUBLE:   cfg_q.double_click_ticks <= cfg_data;
				bchd_pkg::REG_HOLD:     cfg_q.hold_ticks         <= cfg_data;
				bchd_pkg::REG_POLARITY: cfg_q.active_high        <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pin_s1 <= pin_level;
		end
	end

	// per-tick logic; state commits when the item advances
	bchd_debounce #(
		.TIMER_BITS (TIMER_BITS)
	) u_debounce (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.pin        (pin_s1),
		.cfg        (cfg_q),
		.level_next (level_next)
	);

	bchd_gesture #(
		.TIMER_BITS (TIMER_BITS)
	) u_gesture (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.level  (level_next),
		.cfg    (cfg_q),
		.ev     (ev)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q   <= ev;
			pressed_q <= level_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_code  = event_q;
	assign pressed_now = pressed_q;

endmodule

/* rtl/bchd_checker.sv */
// ----------------------------------------------------------------------------
// bchd_checker: port-level checks for the button click/hold detector
// Output hold under stall and consistency of events with the pressed bit.
// ----------------------------------------------------------------------------
module bchd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [bchd_pkg::EV_W-1:0]         event_code,
	input logic                              pressed_now
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code) && $stable(pressed_now))
		else $error("result changed under stall");

	// a click is reported only after release
	a_click_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == bchd_pkg::EV_CLICK |-> !pressed_now)
		else $error("click while pressed");

	// double click and hold are reported while pressed
	a_press_events: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_code == bchd_pkg::EV_DOUBLE || event_code == bchd_pkg::EV_HOLD)
		|-> pressed_now)
		else $error("double click or hold while released");

	// no hold reported on two transfers in back-to-back cycles
	a_hold_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && event_code == bchd_pkg::EV_HOLD
		##1 out_valid && !out_stall |-> event_code != bchd_pkg::EV_HOLD)
		else $error("hold repeated");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (.*);

/* verif/button_click_hold_detector_tb.sv */
// ----------------------------------------------------------------------------
// button_click_hold_detector_tb: self-checking bench for the click/hold detector
// A directed table covers reset values, register extremes, the zero-threshold
// cases, the release on the hold tick and the polarity flip. Random phases of
// press/release runs with noise follow, each under fresh register values and
// another mix of sender gaps and receiver stalls. Every result transfer is
// compared field by field against an in-bench model of the debounce and the
// gesture machine, or against the hand-typed expectation of a typed row.
// ----------------------------------------------------------------------------
module button_click_hold_detector_tb;

	localparam int TB_TIMER_W  = bchd_pkg::TIMER_BITS_DEF;
	localparam int TB_CFG_W    = bchd_pkg::CFG_W;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_LIMIT = 5000;
	localparam int N_DIR       = 35;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 48;
	localparam int HOLDOFF_LEN = 200;

	typedef enum logic [3:0] {
		G_IDLE    = 4'b0001,
		G_PRESSED = 4'b0010,
		G_WAIT    = 4'b0100,
		G_HOLD    = 4'b1000
	} gesture_t;

	typedef struct packed {
		logic [bchd_pkg::EV_W-1:0] ev;
		logic                      pressed;
	} tick_result_t;

	typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

	// one directed step: either a register write or a tick, the latter with an
	// optional hand-typed expectation (typed = 0 leaves it to the model)
	typedef struct packed {
		row_kind_t                      kind;
		logic [bchd_pkg::CFG_IDX_W-1:0] idx;
		logic [bchd_pkg::CFG_W-1:0]     data;
		logic                           pin;
		bit                             typed;
		logic [bchd_pkg::EV_W-1:0]      ev;
		logic                           pressed;
	} dir_row_t;

	// ------------------------------------------------------------------------
	// DUT connections, all known from time zero
	// ------------------------------------------------------------------------
	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           in_valid    = 1'b0;
	logic                           in_stall;
	logic                           pin_level   = 1'b0;
	logic                           out_valid;
	logic                           out_stall   = 1'b0;
	logic [bchd_pkg::EV_W-1:0]      event_code;
	logic                           pressed_now;
	logic                           cfg_we      = 1'b0;
	logic [bchd_pkg::CFG_IDX_W-1:0] cfg_index   = bchd_pkg::REG_DEBOUNCE;
	logic [bchd_pkg::CFG_W-1:0]     cfg_data    = '0;

	// side info that travels with each offered tick
	bit                             row_typed   = 1'b0;
	logic [bchd_pkg::EV_W-1:0]      row_ev      = bchd_pkg::EV_NONE;
	logic                           row_pressed = 1'b0;

	// traffic shaping
	int                   tx_idle_pct    = 0;
	int                   rx_stall_pct   = 0;
	bit                   holdoff_toggle = 1'b0;
	bit                   holdoff_seen   = 1'b0;
	int                   holdoff_left   = 0;

	int                   cycle_cnt    = 0;
	int                   mismatch_cnt = 0;
	int                   result_cnt   = 0;
	int                   sent_cnt     = 0;

	tick_result_t         pending_results [$];

	// ------------------------------------------------------------------------
	// model state, mirrors the block's registers and timers
	// ------------------------------------------------------------------------
	bchd_pkg::cfg_t        cfg_m = '{debounce_ticks: bchd_pkg::DEBOUNCE_RST,
		double_click_ticks: bchd_pkg::DOUBLE_RST, hold_ticks: bchd_pkg::HOLD_RST,
		active_high: 1'b0};
	logic [TB_TIMER_W-1:0] m_stable   = '0;
	logic                  m_prev_raw = 1'b0;
	logic                  m_level    = 1'b0;
	gesture_t              m_mode     = G_IDLE;
	logic [TB_TIMER_W-1:0] m_press    = '0;
	logic [TB_TIMER_W-1:0] m_gap      = '0;

	// directed table; comments give the model's view after the tick
	dir_row_t dir_rows [N_DIR] = '{
		// reset values: active low, debounce 50, nothing can be accepted yet
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b1, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, bchd_pkg::EV_NONE, 1'b0},
		// all thresholds at zero, active high
		'{ROW_WRITE, bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_WRITE, bchd_pkg::REG_HOLD,     16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_WRITE, bchd_pkg::REG_DOUBLE,   16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_WRITE, bchd_pkg::REG_POLARITY, 16'h0001, 1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		// polarity flip restarts debounce, press lands, hold one tick later
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		// short press, second press inside a huge gap -> double click,
		// then release exactly on the hold tick -> silent return to idle
		'{ROW_WRITE, bchd_pkg::REG_HOLD,     16'd3,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_WRITE, bchd_pkg::REG_DOUBLE,   16'hffff, 1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		// zero gap: click one tick after the release
		'{ROW_WRITE, bchd_pkg::REG_DOUBLE,   16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		// maximum debounce can never accept; upper data bits of the
		// polarity write must be dropped
		'{ROW_WRITE, bchd_pkg::REG_DEBOUNCE, 16'hffff, 1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_WRITE, bchd_pkg::REG_HOLD,     16'hffff, 1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_WRITE, bchd_pkg::REG_POLARITY, 16'hfffe, 1'b0, 1'b0, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b1, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b0, 1'b1, bchd_pkg::EV_NONE, 1'b0},
		'{ROW_TICK,  bchd_pkg::REG_DEBOUNCE, 16'd0,    1'b1, 1'b1, bchd_pkg::EV_NONE, 1'b0}
	};

	button_click_hold_detector i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pin_level   (pin_level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_code  (event_code),
		.pressed_now (pressed_now),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// model
	// ------------------------------------------------------------------------
	function automatic logic [TB_TIMER_W-1:0] sat_inc(logic [TB_TIMER_W-1:0] t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	// advances the model by one tick and returns the event and debounced bit
	function automatic tick_result_t classify_tick(logic pin);
		logic         raw;
		tick_result_t r;
		raw = cfg_m.active_high ? pin : ~pin;
		r.ev = bchd_pkg::EV_NONE;

		// debounce: a level change restarts the stability count
		if (raw != m_prev_raw)
			m_stable = '0;
		else
			m_stable = sat_inc(m_stable);
		if (m_stable > cfg_m.debounce_ticks)
			m_level = raw;
		m_prev_raw = raw;

		case (m_mode)
		G_IDLE: begin
			if (m_level) begin
				m_mode  = G_PRESSED;
				m_press = '0;
			end
		end
		G_PRESSED: begin
			m_press = sat_inc(m_press);
			if (!m_level) begin
				// a release on the hold tick is swallowed
				if (m_press >= cfg_m.hold_ticks) begin
					m_mode = G_IDLE;
				end else begin
					m_mode = G_WAIT;
					m_gap  = '0;
				end
			end else if (m_press >= cfg_m.hold_ticks) begin
				m_mode = G_HOLD;
				r.ev   = bchd_pkg::EV_HOLD;
			end
		end
		G_WAIT: begin
			m_gap = sat_inc(m_gap);
			if (m_level) begin
				m_mode  = G_PRESSED;
				m_press = '0;
				r.ev    = bchd_pkg::EV_DOUBLE;
			end else if (m_gap >= cfg_m.double_click_ticks) begin
				m_mode = G_IDLE;
				r.ev   = bchd_pkg::EV_CLICK;
			end
		end
		G_HOLD: begin
			if (!m_level)
				m_mode = G_IDLE;
		end
		default: begin
			m_mode = G_IDLE;
		end
		endcase

		r.pressed = m_level;
		return r;
	endfunction

	// mostly small thresholds so every gesture is reachable, sometimes any value
	function automatic logic [bchd_pkg::CFG_W-1:0] pick_threshold(int unsigned top);
		if ($urandom_range(99) < 85)
			return TB_CFG_W'($urandom_range(top));
		return TB_CFG_W'($urandom_range(16'hffff));
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_cnt < 100)
			$display("MISMATCH @%0d: %s", cycle_cnt, msg);
		mismatch_cnt++;
	endtask

	// ------------------------------------------------------------------------
	// driver side
	// ------------------------------------------------------------------------
	// offers one tick, with random idle cycles first; returns after the transfer
	task automatic send_tick(input logic pin, input bit typed,
			input logic [bchd_pkg::EV_W-1:0] ev, input logic pressed);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		pin_level   <= pin;
		row_typed   <= typed;
		row_ev      <= ev;
		row_pressed <= pressed;
		do
			@(posedge clk);
		while (in_stall);
		sent_cnt++;
	endtask

	// registers only change while nothing is in flight
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// one write pulse; the enable is back low before the task returns
	task automatic write_reg(input logic [bchd_pkg::CFG_IDX_W-1:0] idx,
			input logic [bchd_pkg::CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		bchd_pkg::REG_DEBOUNCE: cfg_m.debounce_ticks     = val;
		bchd_pkg::REG_DOUBLE:   cfg_m.double_click_ticks = val;
		bchd_pkg::REG_HOLD:     cfg_m.hold_ticks         = val;
		bchd_pkg::REG_POLARITY: cfg_m.active_high        = val[0];
		default: begin
		end
		endcase
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// receiver: random stalls plus a long hold-off started by the stimulus
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (holdoff_toggle != holdoff_seen) begin
			holdoff_seen <= holdoff_toggle;
			holdoff_left <= HOLDOFF_LEN;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end
		out_stall <= (holdoff_toggle != holdoff_seen) || (holdoff_left > 1) ||
			($urandom_range(99) < rx_stall_pct);
	end

	// ------------------------------------------------------------------------
	// monitor: check result transfers first, then log input transfers
	// (a result can never belong to a tick taken at the same edge)
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		tick_result_t want;
		tick_result_t model_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing outstanding",
					result_cnt));
			end else begin
				want = pending_results.pop_front();
				if (event_code !== want.ev)
					report_mismatch($sformatf("result %0d: event_code %0d, expected %0d",
						result_cnt, event_code, want.ev));
				if (pressed_now !== want.pressed)
					report_mismatch($sformatf("result %0d: pressed_now %0b, expected %0b",
						result_cnt, pressed_now, want.pressed));
			end
			result_cnt++;
		end
		if (arst_n && in_valid && !in_stall) begin
			// the model always advances; typed rows override its answer
			model_res = classify_tick(pin_level);
			if (row_typed)
				pending_results.push_back(tick_result_t'{ev: row_ev, pressed: row_pressed});
			else
				pending_results.push_back(model_res);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		int         ph;
		int         start;
		int         kind;
		int         len;
		int         span;
		int         waited;
		bit         holdoff_done;
		logic       pin;

		holdoff_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_tick(dir_rows[i].pin, dir_rows[i].typed, dir_rows[i].ev,
					dir_rows[i].pressed);
			end
		end

		// random phases, each with new register values and idling mix
		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			write_reg(bchd_pkg::REG_DEBOUNCE, pick_threshold(4));
			write_reg(bchd_pkg::REG_DOUBLE, pick_threshold(8));
			write_reg(bchd_pkg::REG_HOLD, pick_threshold(12));
			write_reg(bchd_pkg::REG_POLARITY, TB_CFG_W'($urandom_range(16'hffff)));
			case (ph % 4)
			0: begin
				tx_idle_pct  = 0;
				rx_stall_pct = 0;
			end
			1: begin
				tx_idle_pct  = 57;
				rx_stall_pct = 0;
			end
			2: begin
				tx_idle_pct  = 0;
				rx_stall_pct = 57;
			end
			default: begin
				tx_idle_pct  = 8;
				rx_stall_pct = 8;
			end
			endcase

			start = sent_cnt;
			while (sent_cnt - start < PHASE_ITEMS) begin
				// long receiver hold-off while the sender keeps offering
				if (ph == 4 && !holdoff_done && sent_cnt - start >= 8) begin
					holdoff_toggle <= ~holdoff_toggle;
					holdoff_done = 1'b1;
				end
				kind = $urandom_range(9);
				if (kind < 7) begin
					// well-formed press then release, lengths around thresholds
					span = cfg_m.debounce_ticks + cfg_m.hold_ticks + 3;
					if (span > 40)
						span = 40;
					len = $urandom_range(span, 1);
					repeat (len) send_tick(cfg_m.active_high, 1'b0, bchd_pkg::EV_NONE, 1'b0);
					span = cfg_m.debounce_ticks + cfg_m.double_click_ticks + 3;
					if (span > 40)
						span = 40;
					len = $urandom_range(span, 1);
					repeat (len) send_tick(~cfg_m.active_high, 1'b0, bchd_pkg::EV_NONE, 1'b0);
				end else begin
					// bounce noise
					len = $urandom_range(6, 1);
					repeat (len) begin
						pin = 1'($urandom_range(1));
						send_tick(pin, 1'b0, bchd_pkg::EV_NONE, 1'b0);
					end
				end
			end
		end

		// let everything outstanding come out, then watch for strays
		in_valid     <= 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		if (mismatch_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/bchd_pkg.sv
rtl/bchd_debounce.sv
rtl/bchd_gesture.sv
rtl/button_click_hold_detector.sv
rtl/bchd_checker.sv
verif/button_click_hold_detector_tb.sv
